### rtl/misa_pkg.sv
// Shared constants, codes and types of the mixer input slot allocator.
package misa_pkg;

    // Table geometry.
    localparam int NUM_ENTRIES = 8;
    localparam int NUM_SLOTS   = 8;
    localparam int ENTRY_W     = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);

    // Field widths.
    localparam int SLOT_W      = 3;
    localparam int STRIDE_W    = 4;
    localparam int MEDIA_W     = 8;
    localparam int TAG_W       = 32;
    localparam int IDX_W       = 8;
    localparam int TIME_W      = 64;
    localparam int OUT_ENTRY_W = 3;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = 120;
    localparam int OUT_DATA_W  = 8;

    // The stored stride never exceeds the table size or the register range, so a
    // slot's next index never exceeds the larger of its reset value and the last
    // entry plus the widest stride.
    localparam int MAX_STRIDE  = (NUM_ENTRIES < 15) ? NUM_ENTRIES : 15;
    localparam int NEXT_MAX    = ((NUM_ENTRIES - 1 + MAX_STRIDE) > (NUM_SLOTS - 1)) ?
                                 (NUM_ENTRIES - 1 + MAX_STRIDE) : (NUM_SLOTS - 1);
    localparam int NEXT_W      = $clog2(NEXT_MAX + 1);

    // Command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_USE   = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_STALE = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_SLOT_STRIDE = 1'b0;
    localparam logic REG_PER_MEDIA   = 1'b1;

    // Control from the sequencer to the oldest-entry scan unit.
    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctrl_t;

    // The entry field carries only the low bits of an entry number.
    function automatic logic [OUT_ENTRY_W-1:0] out_entry(input logic [IDX_W-1:0] value);
        return value[OUT_ENTRY_W-1:0];
    endfunction

endpackage

### rtl/misa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module misa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/misa_scan.sv
// Oldest-entry scan unit: one shared 64-bit compare stepped over the table.
module misa_scan
    import misa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  scan_ctrl_t          ctrl,
    input  logic [SLOT_W-1:0]   slot,
    input  logic [STRIDE_W-1:0] stride,
    input  logic [TIME_W-1:0]   use_time,
    output logic [ENTRY_W-1:0]  pick
);

    logic [TIME_W-1:0]   oldest_reg;
    logic [TIME_W-1:0]   oldest_next;
    logic [ENTRY_W-1:0]  pick_reg;
    logic [ENTRY_W-1:0]  pick_next;
    logic [STRIDE_W-1:0] phase_reg;
    logic [STRIDE_W-1:0] phase_next;
    logic [ENTRY_W-1:0]  index_reg;
    logic [ENTRY_W-1:0]  index_next;
    logic                congruent;
    logic                take;

    // The phase counter tracks the entry number modulo the stride.
    assign congruent = (STRIDE_W'(slot) == phase_reg);
    // A zero time in the current pick counts as unset and is replaced by any congruent entry.
    assign take      = congruent && ((oldest_reg == '0) || (oldest_reg > use_time));

    always_comb
    begin
        oldest_next = oldest_reg;
        pick_next   = pick_reg;
        phase_next  = phase_reg;
        index_next  = index_reg;
        if (ctrl.clear)
        begin
            oldest_next = '0;
            pick_next   = '0;
            phase_next  = '0;
            index_next  = '0;
        end
        else if (ctrl.step)
        begin
            if (take)
            begin
                oldest_next = use_time;
                pick_next   = index_reg;
            end
            phase_next = (STRIDE_W'(phase_reg + 1'b1) == stride) ? '0 :
                         STRIDE_W'(phase_reg + 1'b1);
            index_next = ENTRY_W'(index_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            pick_reg   <= '0;
            phase_reg  <= '0;
            index_reg  <= '0;
        end
        else
        begin
            oldest_reg <= oldest_next;
            pick_reg   <= pick_next;
            phase_reg  <= phase_next;
            index_reg  <= index_next;
        end
    end

    assign pick = pick_reg;

endmodule

### rtl/mixer_input_slot_allocator_unit.sv
// Top level of the mixer input slot allocator: sequencer, tables and ports.
//
// Usage: requests enter on the s_ channel (s_tuser is the command, allocate or
// use) and each request produces exactly one result on the m_ channel. An
// allocate request grants a table entry to a stream slot; a use request checks
// the entry's owner and stamps its use time.
// A direct grant or an out-of-range use passes the decide and finish states
// from acceptance to the result register, an in-range use also passes the
// owner check state, and an allocate that recycles an entry passes the scan,
// drain and recycle states. The scan that picks the entry to recycle reads
// the use-time memory one entry per cycle through a single read port and
// feeds one shared compare, which sets the length of a recycling allocate.
// One request is worked on at a time; a new one is taken only in idle.
// Reset clears the owner and use-time tables through per-entry valid bits,
// sets each slot's next index to its own number, the stride to one and
// per-media mode off; no clearing pass is needed.
// When the receiver stalls, the finished result waits in the output register
// and one more request is accepted and worked on; that request then holds in
// its final state until the output register frees up.
module mixer_input_slot_allocator_unit
    import misa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Request channel.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata from bit 0: stream_slot[2:0], media_id[10:3], owner_tag[42:11],
    // entry_index[50:43], time_now[114:51], zero fill [119:115].
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: cmd (0 allocate, 1 use).
    input  logic                  s_tuser,
    // Result channel.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata from bit 0: entry[2:0], status[4:3], recycled[5], zero fill [7:6].
    output logic [OUT_DATA_W-1:0] m_tdata,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DECIDE  = 3'd1;
    localparam logic [2:0] ST_CHECK   = 3'd2;
    localparam logic [2:0] ST_SCAN    = 3'd3;
    localparam logic [2:0] ST_DRAIN   = 3'd4;
    localparam logic [2:0] ST_RECYCLE = 3'd5;
    localparam logic [2:0] ST_FINISH  = 3'd6;

    // Configuration registers.
    logic [STRIDE_W-1:0] stride_reg;
    logic                per_media_reg;
    logic                cfg_we;
    logic [STRIDE_W-1:0] stride_wr;

    // Sequencer and scan counter.
    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] scan_cnt_reg;
    logic [CNT_W-1:0] scan_cnt_next;
    logic             scan_step_reg;

    // Latched request.
    logic                cmd_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [MEDIA_W-1:0]  media_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [TIME_W-1:0]   now_reg;
    logic                accept;

    // Result under construction and the output register.
    logic [OUT_ENTRY_W-1:0] res_entry_reg;
    logic [OUT_ENTRY_W-1:0] res_entry_next;
    logic [STATUS_W-1:0]    res_status_reg;
    logic [STATUS_W-1:0]    res_status_next;
    logic                   res_recycled_reg;
    logic                   res_recycled_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic                   out_load;

    // Per-slot next index.
    logic [NEXT_W-1:0] next_index_reg [NUM_SLOTS];
    logic              nidx_we;
    logic [NEXT_W-1:0] nidx_wdata;

    // Owner and use-time tables with their valid bits.
    logic [NUM_ENTRIES-1:0] owner_vld_reg;
    logic [NUM_ENTRIES-1:0] time_vld_reg;
    logic                   owner_vld_q_reg;
    logic                   time_vld_q_reg;
    logic                   owner_we;
    logic [ENTRY_W-1:0]     owner_waddr;
    logic [TAG_W-1:0]       owner_rdata;
    logic [ENTRY_W-1:0]     owner_raddr;
    logic                   time_we;
    logic [ENTRY_W-1:0]     time_waddr;
    logic [TIME_W-1:0]      time_wdata;
    logic [TIME_W-1:0]      time_rdata;
    logic [ENTRY_W-1:0]     time_raddr;
    logic [TAG_W-1:0]       owner_eff;
    logic [TIME_W-1:0]      time_eff;

    // Allocation decode.
    logic [IDX_W-1:0]   cand;
    logic               cand_direct;
    logic [ENTRY_W-1:0] pick;
    scan_ctrl_t         scan_ctrl;

    // ------------------------------------------------------------------
    // Configuration port. Writes are zero-wait; the stride is stored clamped.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite;
    assign stride_wr = (pwdata[STRIDE_W-1:0] == '0) ? STRIDE_W'(1) :
                       (IDX_W'(pwdata[STRIDE_W-1:0]) > IDX_W'(NUM_ENTRIES)) ?
                       STRIDE_W'(NUM_ENTRIES) : pwdata[STRIDE_W-1:0];

    always_comb
    begin
        unique case (paddr[2])
            REG_SLOT_STRIDE: prdata = 32'(stride_reg);
            REG_PER_MEDIA:   prdata = 32'(per_media_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg    <= STRIDE_W'(1);
            per_media_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (paddr[2])
                REG_SLOT_STRIDE: stride_reg    <= stride_wr;
                REG_PER_MEDIA:   per_media_reg <= pwdata[0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request intake.
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= s_tuser;
            slot_reg  <= s_tdata[2:0];
            media_reg <= s_tdata[10:3];
            tag_reg   <= s_tdata[42:11];
            idx_reg   <= s_tdata[50:43];
            now_reg   <= s_tdata[114:51];
        end
    end

    // ------------------------------------------------------------------
    // Tables. A never-written entry reads as zero through its valid bit.
    // ------------------------------------------------------------------
    misa_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NUM_ENTRIES)
    ) u_owner_ram (
        .clk   (clk),
        .we    (owner_we),
        .waddr (owner_waddr),
        .wdata (tag_reg),
        .raddr (owner_raddr),
        .rdata (owner_rdata)
    );

    misa_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NUM_ENTRIES)
    ) u_time_ram (
        .clk   (clk),
        .we    (time_we),
        .waddr (time_waddr),
        .wdata (time_wdata),
        .raddr (time_raddr),
        .rdata (time_rdata)
    );

    // The owner table is read only by use requests; the time table only by the scan.
    assign owner_raddr = idx_reg[ENTRY_W-1:0];
    assign time_raddr  = scan_cnt_reg[ENTRY_W-1:0];
    assign owner_eff   = owner_vld_q_reg ? owner_rdata : '0;
    assign time_eff    = time_vld_q_reg ? time_rdata : '0;

    // ------------------------------------------------------------------
    // Shared compare unit for the oldest-entry scan.
    // ------------------------------------------------------------------
    misa_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (scan_ctrl),
        .slot     (slot_reg),
        .stride   (stride_reg),
        .use_time (time_eff),
        .pick     (pick)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign cand        = per_media_reg ? media_reg : IDX_W'(next_index_reg[slot_reg]);
    assign cand_direct = (cand < IDX_W'(NUM_ENTRIES));
    assign out_load    = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next        = state_reg;
        scan_cnt_next     = scan_cnt_reg;
        res_entry_next    = res_entry_reg;
        res_status_next   = res_status_reg;
        res_recycled_next = res_recycled_reg;
        scan_ctrl         = '0;
        nidx_we           = 1'b0;
        nidx_wdata        = next_index_reg[slot_reg];
        owner_we          = 1'b0;
        owner_waddr       = cand[ENTRY_W-1:0];
        time_we           = 1'b0;
        time_waddr        = idx_reg[ENTRY_W-1:0];
        time_wdata        = now_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                res_status_next   = STATUS_OK;
                res_recycled_next = 1'b0;
                if (cmd_reg == CMD_ALLOC)
                begin
                    // In slot mode the slot's next index advances by the stride.
                    if (!per_media_reg)
                    begin
                        nidx_we    = 1'b1;
                        nidx_wdata = NEXT_W'(next_index_reg[slot_reg] + stride_reg);
                    end
                    if (cand_direct)
                    begin
                        // A direct grant sets the owner and keeps the use time.
                        owner_we       = 1'b1;
                        res_entry_next = out_entry(cand);
                        state_next     = ST_FINISH;
                    end
                    else
                    begin
                        scan_ctrl.clear = 1'b1;
                        scan_cnt_next   = '0;
                        state_next      = ST_SCAN;
                    end
                end
                else
                begin
                    res_entry_next = out_entry(idx_reg);
                    if (idx_reg >= IDX_W'(NUM_ENTRIES))
                    begin
                        res_status_next = STATUS_RANGE;
                        state_next      = ST_FINISH;
                    end
                    else
                    begin
                        // The owner read is issued this cycle and checked next.
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (owner_eff == tag_reg)
                begin
                    time_we = 1'b1;
                end
                else
                begin
                    res_status_next = STATUS_STALE;
                end
                state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                // One time-table read per cycle; the compare of each read follows in the next cycle.
                scan_ctrl.step = scan_step_reg;
                scan_cnt_next  = CNT_W'(scan_cnt_reg + 1'b1);
                if (scan_cnt_reg == CNT_W'(NUM_ENTRIES - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                scan_ctrl.step = scan_step_reg;
                state_next     = ST_RECYCLE;
            end
            ST_RECYCLE:
            begin
                // Reclaim the oldest entry and rewind the slot to it.
                owner_we          = 1'b1;
                owner_waddr       = pick;
                time_we           = 1'b1;
                time_waddr        = pick;
                time_wdata        = '0;
                nidx_we           = 1'b1;
                nidx_wdata        = NEXT_W'(pick);
                res_entry_next    = out_entry(IDX_W'(pick));
                res_recycled_next = 1'b1;
                state_next        = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output register is free once its result has been taken.
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            scan_step_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            owner_vld_reg <= '0;
            time_vld_reg  <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                next_index_reg[i] <= NEXT_W'(i);
            end
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            scan_step_reg <= (state_reg == ST_SCAN);
            out_valid_reg <= out_valid_next;
            if (owner_we)
            begin
                owner_vld_reg[owner_waddr] <= 1'b1;
            end
            if (time_we)
            begin
                time_vld_reg[time_waddr] <= 1'b1;
            end
            if (nidx_we)
            begin
                next_index_reg[slot_reg] <= nidx_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        owner_vld_q_reg  <= owner_vld_reg[owner_raddr];
        time_vld_q_reg   <= time_vld_reg[time_raddr];
        res_entry_reg    <= res_entry_next;
        res_status_reg   <= res_status_next;
        res_recycled_reg <= res_recycled_next;
        if (out_load)
        begin
            out_data_reg <= {2'b00, res_recycled_reg, res_status_reg, res_entry_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### rtl/misa_checker.sv
// Port-level assertions for the mixer input slot allocator and their binding.
module misa_checker
    import misa_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // Only one request is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another request is in work");

    // A recycled grant is always reported with status ok.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[5]) |-> (m_tdata[4:3] == STATUS_OK))
    else $error("recycled result carries a nonzero status");

    // The status field never holds the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[4:3] != 2'b11))
    else $error("result status holds an undefined code");

    // A stalled result stays valid and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result dropped or changed");

endmodule

bind mixer_input_slot_allocator_unit misa_checker u_misa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/mixer_input_slot_allocator_unit_tb.sv
// Self-checking testbench of the mixer input slot allocator: directed table, then random traffic.
`timescale 1ns / 100ps

module mixer_input_slot_allocator_unit_tb
    import misa_pkg::*;
();

    // The run ends with a failure if this many cycles pass with no handshake anywhere.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles allowed for the block to settle once nothing is pending any more.
    localparam int SETTLE_CYCLES  = 16;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_REQUESTS = 68;

    // One request as it goes in on the s_ channel.
    typedef struct {
        logic              cmd;
        logic [SLOT_W-1:0] slot;
        logic [MEDIA_W-1:0] media;
        logic [TAG_W-1:0]  tag;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] now;
    } request_t;

    // One result as it comes out on the m_ channel.
    typedef struct {
        logic [OUT_ENTRY_W-1:0] entry;
        logic [STATUS_W-1:0]    status;
        logic                   recycled;
    } grant_t;

    typedef enum {
        ROW_REQUEST,
        ROW_SETTING
    } row_kind_t;

    // A row of the directed table: either a register write or a request, the
    // latter with an optional typed-in result.
    typedef struct {
        row_kind_t kind;
        logic      reg_sel;
        logic [31:0] value;
        request_t  req;
        bit        known;
        grant_t    want;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // s_tdata from bit 0: stream_slot, media_id, owner_tag, entry_index, time_now, zero fill.
    logic [IN_DATA_W-1:0]  s_tdata;
    // s_tuser: cmd.
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // m_tdata from bit 0: entry, status, recycled, zero fill.
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    mixer_input_slot_allocator_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the allocator's tables and registers, kept in step with
    // every accepted request and every register write.
    logic [7:0]        slot_next [NUM_SLOTS];
    logic [TIME_W-1:0] use_stamp [NUM_ENTRIES];
    logic [TAG_W-1:0]  owner_of  [NUM_ENTRIES];
    int unsigned       stride_now;
    bit                media_mode;

    // Results predicted but not yet seen, oldest first.
    grant_t pending_grants[$];
    row_t   plan[$];
    int     error_count;

    // A small set of owner tags, so that use requests often name the right owner.
    logic [TAG_W-1:0] tag_pool [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_5A5A,
                                      32'h1234_5678};

    // Strides and modes of the random phases. Stride zero and fifteen check
    // that the register clamps into one through the table size.
    int unsigned phase_stride [RANDOM_PHASES] = '{1, 8, 2, 3, 15, 0, 5, 4, 7, 6};
    bit          phase_media  [RANDOM_PHASES] = '{0, 0, 1, 0, 1, 0, 1, 1, 0, 0};

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void reset_shadow();
        for (int i = 0; i < NUM_SLOTS; i++)
            slot_next[i] = 8'(i);
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            use_stamp[i] = '0;
            owner_of[i]  = '0;
        end
        stride_now = 1;
        media_mode = 1'b0;
    endfunction

    function automatic void apply_setting(logic reg_sel, logic [31:0] value);
        int unsigned v;
        if (reg_sel == REG_SLOT_STRIDE)
        begin
            v = value[3:0];
            if (v < 1)
                v = 1;
            if (v > NUM_ENTRIES)
                v = NUM_ENTRIES;
            stride_now = v;
        end
        else
            media_mode = value[0];
    endfunction

    // Entry to recycle for a slot. The scan walks up the table; a congruent
    // entry takes over whenever the current pick still has a zero time, which
    // reads as unset, or a later time. Entry zero wins when nothing is congruent.
    function automatic int unsigned oldest_for_slot(int unsigned slot);
        int unsigned       pick;
        logic [TIME_W-1:0] oldest;
        pick   = 0;
        oldest = '0;
        for (int unsigned i = 0; i < NUM_ENTRIES; i++)
        begin
            if ((oldest == 0 || oldest > use_stamp[i]) && (i % stride_now) == slot)
            begin
                pick   = i;
                oldest = use_stamp[i];
            end
        end
        return pick;
    endfunction

    // Works out the result of one accepted request and updates the shadow tables.
    function automatic grant_t predict_grant(request_t r);
        grant_t      g;
        int unsigned e;
        g.status   = STATUS_OK;
        g.recycled = 1'b0;
        if (r.cmd == CMD_ALLOC)
        begin
            if (media_mode)
                e = r.media;
            else
            begin
                e = slot_next[r.slot];
                slot_next[r.slot] = 8'(e + stride_now);
            end
            if (e < NUM_ENTRIES)
                owner_of[e] = r.tag;  // a direct grant leaves the use time alone
            else
            begin
                e = oldest_for_slot(r.slot);
                use_stamp[e]      = '0;
                owner_of[e]       = r.tag;
                slot_next[r.slot] = 8'(e);
                g.recycled        = 1'b1;
            end
        end
        else
        begin
            e = r.idx;
            if (r.idx >= NUM_ENTRIES)
                g.status = STATUS_RANGE;
            else if (owner_of[r.idx] != r.tag)
                g.status = STATUS_STALE;
            else
                use_stamp[r.idx] = r.now;
        end
        g.entry = OUT_ENTRY_W'(e);
        return g;
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------

    function automatic void plan_request(logic cmd, logic [SLOT_W-1:0] slot,
                                         logic [MEDIA_W-1:0] media, logic [TAG_W-1:0] tag,
                                         logic [IDX_W-1:0] idx, logic [TIME_W-1:0] now);
        row_t row;
        row.kind    = ROW_REQUEST;
        row.reg_sel = 1'b0;
        row.value   = '0;
        row.req     = '{cmd, slot, media, tag, idx, now};
        row.known   = 1'b0;
        row.want    = '{'0, '0, 1'b0};
        plan.push_back(row);
    endfunction

    function automatic void plan_checked(logic cmd, logic [SLOT_W-1:0] slot,
                                         logic [MEDIA_W-1:0] media, logic [TAG_W-1:0] tag,
                                         logic [IDX_W-1:0] idx, logic [TIME_W-1:0] now,
                                         logic [OUT_ENTRY_W-1:0] entry,
                                         logic [STATUS_W-1:0] status, logic recycled);
        plan_request(cmd, slot, media, tag, idx, now);
        plan[plan.size()-1].known = 1'b1;
        plan[plan.size()-1].want  = '{entry, status, recycled};
    endfunction

    function automatic void plan_setting(logic reg_sel, logic [31:0] value);
        row_t row;
        row.kind    = ROW_SETTING;
        row.reg_sel = reg_sel;
        row.value   = value;
        row.req     = '{1'b0, '0, '0, '0, '0, '0};
        row.known   = 1'b0;
        row.want    = '{'0, '0, 1'b0};
        plan.push_back(row);
    endfunction

    function automatic void build_plan();
        // Right after reset every owner is zero, so a zero tag passes.
        plan_checked(CMD_USE, 3'd0, 8'd0, 32'h0, 8'd0, 64'h0, 3'd0, STATUS_OK, 1'b0);
        // Indexes past the table: the entry field echoes the low bits.
        plan_checked(CMD_USE, 3'd7, 8'hFF, 32'hFFFF_FFFF, 8'hFF, '1, 3'd7, STATUS_RANGE, 1'b0);
        plan_checked(CMD_USE, 3'd0, 8'd0, 32'h0, 8'd8, 64'd5, 3'd0, STATUS_RANGE, 1'b0);
        // Direct grant to slot zero, after which the old zero tag is stale.
        plan_checked(CMD_ALLOC, 3'd0, 8'd0, 32'hFFFF_FFFF, 8'd0, 64'd0, 3'd0, STATUS_OK, 1'b0);
        plan_checked(CMD_USE, 3'd0, 8'd0, 32'h0, 8'd0, 64'd9, 3'd0, STATUS_STALE, 1'b0);
        plan_request(CMD_USE, 3'd0, 8'd0, 32'hFFFF_FFFF, 8'd0, '1);
        // Slot seven runs past the table with stride one: nothing is
        // congruent, so entry zero is recycled.
        plan_request(CMD_ALLOC, 3'd7, 8'd0, 32'd1, 8'd0, 64'd0);
        plan_checked(CMD_ALLOC, 3'd7, 8'd0, 32'd2, 8'd0, 64'd0, 3'd0, STATUS_OK, 1'b1);
        // Stride register clamping at both ends.
        plan_setting(REG_SLOT_STRIDE, 32'd0);
        plan_setting(REG_SLOT_STRIDE, 32'd15);
        plan_request(CMD_ALLOC, 3'd3, 8'd0, 32'd5, 8'd0, 64'd0);
        plan_request(CMD_ALLOC, 3'd3, 8'd0, 32'd6, 8'd0, 64'd0);
        // Stride two, with use times that make the zero-means-unset quirk show.
        plan_setting(REG_SLOT_STRIDE, 32'd2);
        plan_request(CMD_USE, 3'd0, 8'd0, 32'd0, 8'd2, 64'd100);
        plan_request(CMD_USE, 3'd0, 8'd0, 32'd0, 8'd4, 64'd50);
        // Per-media mode: a direct grant, then media ids past the table, one
        // with a congruent slot and one with none.
        plan_setting(REG_PER_MEDIA, 32'd1);
        plan_request(CMD_ALLOC, 3'd1, 8'd0, 32'd3, 8'd0, 64'd0);
        plan_request(CMD_ALLOC, 3'd0, 8'hFF, 32'd4, 8'd0, 64'd0);
        plan_request(CMD_ALLOC, 3'd5, 8'd8, 32'd7, 8'd0, 64'd0);
        plan_request(CMD_ALLOC, 3'd1, 8'd7, 32'd8, 8'd0, 64'd0);
        plan_request(CMD_USE, 3'd0, 8'd0, 32'd8, 8'd7, 64'd1);
        plan_setting(REG_PER_MEDIA, 32'd0);
        plan_setting(REG_SLOT_STRIDE, 32'd1);
        plan_request(CMD_ALLOC, 3'd2, 8'd0, 32'd0, 8'd0, 64'd0);
        plan_request(CMD_USE, 3'd0, 8'd0, 32'h1234_5678, 8'd3, 64'd77);
    endfunction

    // ------------------------------------------------------------------
    // Random requests
    // ------------------------------------------------------------------

    // Most requests stay on slots that have congruent entries, name entries
    // inside the table and carry the current owner, so that grants, recycling
    // and time stamps all get exercised; the rest is noise.
    function automatic request_t make_request();
        request_t r;
        r.cmd = ($urandom_range(0, 99) < 45) ? CMD_ALLOC : CMD_USE;
        if (stride_now > 1 && $urandom_range(0, 9) < 8)
            r.slot = SLOT_W'($urandom_range(0, stride_now - 1));
        else
            r.slot = SLOT_W'($urandom_range(0, 7));
        if (media_mode && $urandom_range(0, 3) != 0)
            r.media = MEDIA_W'($urandom_range(0, NUM_ENTRIES - 1));
        else
            r.media = MEDIA_W'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
            r.tag = $urandom;
        else
            r.tag = tag_pool[$urandom_range(0, 3)];
        if ($urandom_range(0, 99) < 85)
            r.idx = IDX_W'($urandom_range(0, NUM_ENTRIES - 1));
        else
            r.idx = IDX_W'($urandom_range(0, 255));
        if (r.cmd == CMD_USE && r.idx < NUM_ENTRIES && $urandom_range(0, 9) < 7)
            r.tag = owner_of[r.idx];
        case ($urandom_range(0, 9))
            0:       r.now = '0;
            1:       r.now = '1;
            2, 3:    r.now = TIME_W'($urandom_range(1, 20));  // small values make ties
            default: r.now = {$urandom, $urandom};
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one request and holds it until the block takes it. The predictor
    // runs at the accepting edge, so expectations queue up in order.
    task automatic send_request(request_t r, bit known, grant_t want);
        grant_t g;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tdata  <= {5'b0, r.now, r.idx, r.tag, r.media, r.slot};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        g = predict_grant(r);
        pending_grants.push_back(known ? want : g);
    endtask

    // Gap in the request stream, with junk on the data lines.
    task automatic pause_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tuser  <= 1'($urandom);
            s_tdata  <= IN_DATA_W'({$urandom, $urandom, $urandom, $urandom});
        end
    endtask

    // Stops sending and waits until every predicted result has come out.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the write lands at the access edge.
    task automatic write_setting(logic reg_sel, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        apply_setting(reg_sel, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Clock, stimulus and end of run
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : stimulus
        int     left;
        int     burst;
        grant_t none;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        error_count = 0;
        none = '{'0, '0, 1'b0};
        reset_shadow();
        build_plan();
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: register rows wait for the block to go quiet first.
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_SETTING)
            begin
                drain_results();
                write_setting(plan[i].reg_sel, plan[i].value);
            end
            else
            begin
                send_request(plan[i].req, plan[i].known, plan[i].want);
                pause_sender($urandom_range(0, 3));
            end
        end

        // Random part: two register settings per phase, stride and per-media mode, requests in bursts.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_results();
            write_setting(REG_SLOT_STRIDE, {28'($urandom), 4'(phase_stride[p])});
            write_setting(REG_PER_MEDIA, {31'($urandom), phase_media[p]});
            left = PHASE_REQUESTS;
            while (left > 0)
            begin
                burst = $urandom_range(1, 24);
                while (burst > 0 && left > 0)
                begin
                    send_request(make_request(), 1'b0, none);
                    burst--;
                    left--;
                    // Hold off once mid-phase until everything has come back.
                    if (left == PHASE_REQUESTS / 2 && (p == 2 || $urandom_range(0, 2) == 0))
                        drain_results();
                end
                if ($urandom_range(0, 3) != 0)
                    pause_sender($urandom_range(1, 12));
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("mixer_input_slot_allocator_unit test passed");
        else
            $display("mixer_input_slot_allocator_unit test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // The receiver changes its stall pattern every so often: always ready,
    // coin flips, mostly stalled, or alternating cycles.
    initial
    begin : result_stalls
        int mode;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 150))
            begin
                @(negedge clk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom);
                    2:       m_tready <= ($urandom_range(0, 7) == 0);
                    default: m_tready <= ~m_tready;
                endcase
            end
        end
    end

    // Every accepted result is matched against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        grant_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_grants.size() == 0)
            begin
                $display("%0t: result with no request pending, got entry %0d status %0d recycled %0b",
                         $time, m_tdata[2:0], m_tdata[4:3], m_tdata[5]);
                error_count++;
            end
            else
            begin
                want = pending_grants.pop_front();
                if (m_tdata[2:0] !== want.entry)
                begin
                    $display("%0t: entry expected %0d, got %0d", $time, want.entry, m_tdata[2:0]);
                    error_count++;
                end
                if (m_tdata[4:3] !== want.status)
                begin
                    $display("%0t: status expected %0d, got %0d", $time, want.status,
                             m_tdata[4:3]);
                    error_count++;
                end
                if (m_tdata[5] !== want.recycled)
                begin
                    $display("%0t: recycled expected %0b, got %0b", $time, want.recycled,
                             m_tdata[5]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: any handshake on either channel or the register port counts
    // as progress; a long stretch without one means the block has hung.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable) || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no progress for %0d cycles, %0d results still pending", $time,
                 WATCHDOG_LIMIT, pending_grants.size());
        $display("mixer_input_slot_allocator_unit test failed");
        $finish;
    end

endmodule
